// File: rtl/core/assert_macros.svh
// assert_macros.svh: assertion shorthands shared by the RTL.
// Needs nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while reset is low.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: rtl/core/fspd_pkg.sv
// fspd_pkg: types and constants of the four-step phase decoder.
// No dependencies; used by fspd_cordic, fspd_scale and the top level.
`timescale 1ns / 1ps
package fspd_pkg;

    localparam int C_GREY_W     = 8;
    localparam int C_PERIOD_W   = 8;
    localparam int C_XY_W       = 32;   // CORDIC vector, signed
    localparam int C_ZW         = 26;   // CORDIC angle accumulator, signed, 2^-16 deg
    localparam int C_ANGLE_W    = 25;   // wrapped angle, unsigned, 2^-16 deg
    localparam int C_PHASE_W    = 17;
    localparam int C_OFFSET_W   = 24;
    localparam int C_TERM_SHIFT = 20;
    localparam int C_ATAN_W     = 22;
    localparam int C_ATAN_LEN   = 24;

    localparam logic signed [C_ZW-1:0] C_DEG180_Q16 = 26'sd11796480;
    localparam logic signed [C_ZW-1:0] C_DEG360_Q16 = 26'sd23592960;

    localparam logic [C_PHASE_W-1:0] C_PHASE_WRAP = 17'd92160;
    localparam logic [C_ANGLE_W-1:0] C_PHASE_RND  = 25'd128;

    // floor(v/360) = floor(floor(v/8) * ceil(2^36/45) / 2^36) for v/8 < 2^30
    localparam int C_DIV_W      = 30;
    localparam int C_RECIP_W    = 31;
    localparam int C_RECIP_SHIFT = 36;
    localparam logic [C_RECIP_W-1:0] C_RECIP_45 = 31'd1527099484;
    localparam logic [32:0]           C_HALF_DEG_RND = 33'd180;
    localparam logic [C_OFFSET_W-1:0] C_HALF_PIXEL = 24'd32768;

    localparam logic [C_PERIOD_W-1:0] C_PERIOD_RESET = 8'd16;

    // atan(2^-i) in 2^-16 degree, rounded
    localparam logic [C_ATAN_W-1:0] C_ATAN_Q16 [C_ATAN_LEN] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117304,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0
    };

    typedef struct packed {
        logic [C_ANGLE_W-1:0] angle;
        logic                 last;
    } t_angle_item;

    typedef struct packed {
        logic [C_OFFSET_W-1:0] offset;
        logic [C_PHASE_W-1:0]  phase;
        logic                  last;
    } t_result_item;

endpackage

// File: rtl/core/fspd_cordic.sv
// fspd_cordic: pre-rotation, pipelined CORDIC vectoring and angle wrap.
// Depends on fspd_pkg and assert_macros.svh. One stage per iteration.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fspd_cordic import fspd_pkg::*; #(
    parameter int STAGES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [C_GREY_W-1:0] i_g0,
    input  logic [C_GREY_W-1:0] i_g90,
    input  logic [C_GREY_W-1:0] i_g180,
    input  logic [C_GREY_W-1:0] i_g270,
    input  logic                i_last,
    output logic                o_valid,
    output t_angle_item         o_item
);

    logic signed [C_XY_W-1:0] r_x [STAGES+1];
    logic signed [C_XY_W-1:0] r_y [STAGES+1];
    logic signed [C_ZW-1:0]   r_z [STAGES+1];
    logic                     r_zero [STAGES+1];
    logic                     r_last [STAGES+1];
    logic                     r_vld  [STAGES+1];

    logic signed [C_XY_W-1:0] n_x [STAGES+1];
    logic signed [C_XY_W-1:0] n_y [STAGES+1];
    logic signed [C_ZW-1:0]   n_z [STAGES+1];
    logic                     n_zero [STAGES+1];
    logic                     n_last [STAGES+1];
    logic                     n_vld  [STAGES+1];

    logic signed [C_GREY_W:0]   w_s;
    logic signed [C_GREY_W:0]   w_c;
    logic signed [C_XY_W-1:0]   w_sx;
    logic signed [C_XY_W-1:0]   w_cx;
    logic signed [C_ZW-1:0]     w_zf;
    logic signed [C_ZW-1:0]     w_zw;

    t_angle_item n_item;
    t_angle_item r_item;
    logic        r_out_vld;

    // pre-rotation into the right half plane
    always_comb begin
        w_s  = $signed({1'b0, i_g0}) - $signed({1'b0, i_g180});
        w_c  = $signed({1'b0, i_g90}) - $signed({1'b0, i_g270});
        w_sx = {{(C_XY_W-C_GREY_W-1){w_s[C_GREY_W]}}, w_s};
        w_cx = {{(C_XY_W-C_GREY_W-1){w_c[C_GREY_W]}}, w_c};
        if (w_c[C_GREY_W]) begin
            n_x[0] = (-w_cx) <<< C_TERM_SHIFT;
            n_y[0] = (-w_sx) <<< C_TERM_SHIFT;
            n_z[0] = C_DEG180_Q16;
        end else begin
            n_x[0] = w_cx <<< C_TERM_SHIFT;
            n_y[0] = w_sx <<< C_TERM_SHIFT;
            n_z[0] = '0;
        end
        n_zero[0] = (w_s == '0) && (w_c == '0);
        n_last[0] = i_last;
        n_vld[0]  = i_valid;

        // micro-rotations, one per stage
        for (int i = 0; i < STAGES; i++) begin
            if (!r_y[i][C_XY_W-1]) begin
                n_x[i+1] = r_x[i] + (r_y[i] >>> i);
                n_y[i+1] = r_y[i] - (r_x[i] >>> i);
                n_z[i+1] = r_z[i] + $signed({{(C_ZW-C_ATAN_W){1'b0}}, C_ATAN_Q16[i]});
            end else begin
                n_x[i+1] = r_x[i] - (r_y[i] >>> i);
                n_y[i+1] = r_y[i] + (r_x[i] >>> i);
                n_z[i+1] = r_z[i] - $signed({{(C_ZW-C_ATAN_W){1'b0}}, C_ATAN_Q16[i]});
            end
            n_zero[i+1] = r_zero[i];
            n_last[i+1] = r_last[i];
            n_vld[i+1]  = r_vld[i];
        end
    end

    // wrap into [0, 360)
    always_comb begin
        w_zf = r_z[STAGES];
        if (r_zero[STAGES]) begin
            w_zw = '0;
        end else if (w_zf < 0) begin
            w_zw = w_zf + C_DEG360_Q16;
        end else if (w_zf >= C_DEG360_Q16) begin
            w_zw = w_zf - C_DEG360_Q16;
        end else begin
            w_zw = w_zf;
        end
        n_item.angle = w_zw[C_ANGLE_W-1:0];
        n_item.last  = r_last[STAGES];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= STAGES; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k <= STAGES; k++) begin
                r_vld[k] <= n_vld[k];
            end
            r_out_vld <= r_vld[STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k <= STAGES; k++) begin
                r_x[k]    <= n_x[k];
                r_y[k]    <= n_y[k];
                r_z[k]    <= n_z[k];
                r_zero[k] <= n_zero[k];
                r_last[k] <= n_last[k];
            end
            r_item <= n_item;
        end
    end

    assign o_valid = r_out_vld;
    assign o_item  = r_item;

    `ASSERT_AT(a_angle_wrapped, i_clk, i_rst_n, o_valid |-> ({1'b0, o_item.angle} < C_DEG360_Q16), "CORDIC angle not wrapped below 360 degrees")

endmodule

// File: rtl/core/fspd_scale.sv
// fspd_scale: phase rounding and angle-to-pixel-offset scaling, four stages.
// Depends on fspd_pkg. Division by 360 is a shift and a reciprocal multiply.
`timescale 1ns / 1ps
module fspd_scale import fspd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [C_PERIOD_W-1:0] i_period,
    input  logic                  i_valid,
    input  t_angle_item           i_item,
    output logic                  o_valid,
    output t_result_item          o_item
);

    localparam int C_PROD_W = C_ANGLE_W + C_PERIOD_W;
    localparam int C_MUL_W  = C_DIV_W + C_RECIP_W;

    logic [3:0] r_vld;

    logic [C_PROD_W-1:0]   r1_prod;
    logic [C_PHASE_W-1:0]  r1_phase;
    logic                  r1_last;
    logic [C_DIV_W-1:0]    r2_a;
    logic [C_PHASE_W-1:0]  r2_phase;
    logic                  r2_last;
    logic [C_OFFSET_W-1:0] r3_q;
    logic [C_PHASE_W-1:0]  r3_phase;
    logic                  r3_last;
    t_result_item          r4_item;

    logic [C_ANGLE_W-1:0]  w_rnd;
    logic [C_PHASE_W-1:0]  n1_phase;
    logic [C_PROD_W-1:0]   w_sum;
    logic [C_MUL_W-1:0]    w_mul;
    logic [C_OFFSET_W-1:0] w_offs;
    logic [C_OFFSET_W-1:0] w_lim;
    t_result_item          n4_item;

    always_comb begin
        w_rnd    = i_item.angle + C_PHASE_RND;
        n1_phase = w_rnd[C_ANGLE_W-1:C_ANGLE_W-C_PHASE_W];
        if (n1_phase >= C_PHASE_WRAP) begin
            n1_phase = '0;
        end
        w_sum  = r1_prod + C_HALF_DEG_RND;
        w_mul  = {{C_RECIP_W{1'b0}}, r2_a} * {{C_DIV_W{1'b0}}, C_RECIP_45};
        w_offs = r3_q + C_HALF_PIXEL;
        w_lim  = {i_period, 16'h0000};
        if (w_offs > w_lim) begin
            w_offs = w_offs - w_lim;
        end
        n4_item.offset = w_offs;
        n4_item.phase  = r3_phase;
        n4_item.last   = r3_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_prod  <= {{C_PERIOD_W{1'b0}}, i_item.angle} * {{C_ANGLE_W{1'b0}}, i_period};
            r1_phase <= n1_phase;
            r1_last  <= i_item.last;
            r2_a     <= w_sum[C_PROD_W-1:3];
            r2_phase <= r1_phase;
            r2_last  <= r1_last;
            r3_q     <= w_mul[C_RECIP_SHIFT +: C_OFFSET_W];
            r3_phase <= r2_phase;
            r3_last  <= r2_last;
            r4_item  <= n4_item;
        end
    end

    assign o_valid = r_vld[3];
    assign o_item  = r4_item;

endmodule

// File: rtl/core/four_step_phase_decode_top.sv
// four_step_phase_decode_top: four-step phase-shift fringe decoder, top level.
// Depends on fspd_pkg, fspd_cordic, fspd_scale and assert_macros.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries the four grey levels of
//   one pixel plus the end-of-frame flag; output channel (o_out_valid /
//   i_out_ready) returns pixel offset (16 fraction bits), phase in 1/256
//   degree and the copied frame flag. Each transfer in gives one transfer out,
//   in order.
//   Throughput: one pixel per clock while o_in_ready is high; every stage
//   advances on a shared enable. Registered path from input transfer to
//   o_out_valid: pre-rotation, one stage per CORDIC iteration, wrap, four
//   scaling stages, output buffer.
//   Stall: a two-entry output buffer takes results; the pipeline freezes only
//   when both entries are full, so a new pixel is still taken while one
//   result waits. o_in_ready comes from a register.
//   Configuration: i_cfg_we writes i_cfg_wdata to the fringe period at once;
//   write it only while no pixel is in flight.
//   Reset (i_rst_n low, synchronous): pipeline and buffer emptied, fringe
//   period back to 16.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module four_step_phase_decode_top import fspd_pkg::*; #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [C_PERIOD_W-1:0]  i_cfg_wdata,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [C_GREY_W-1:0]    i_grey_phase0,
    input  logic [C_GREY_W-1:0]    i_grey_phase90,
    input  logic [C_GREY_W-1:0]    i_grey_phase180,
    input  logic [C_GREY_W-1:0]    i_grey_phase270,
    input  logic                   i_last_in_frame,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [C_OFFSET_W-1:0]  o_pixel_offset,
    output logic [C_PHASE_W-1:0]   o_phase_angle,
    output logic                   o_frame_end
);

    logic [C_PERIOD_W-1:0] r_fringe_period;
    logic [1:0]            r_count;
    logic [1:0]            n_count;
    t_result_item          r_buf0;
    t_result_item          r_buf1;

    logic         w_en;
    logic         w_ang_vld;
    t_angle_item  w_ang_item;
    logic         w_res_vld;
    t_result_item w_res_item;
    logic         w_push;
    logic         w_pop;

    assign w_en       = (r_count != 2'd2);
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fringe_period <= C_PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_fringe_period <= i_cfg_wdata;
        end
    end

    fspd_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_g0    (i_grey_phase0),
        .i_g90   (i_grey_phase90),
        .i_g180  (i_grey_phase180),
        .i_g270  (i_grey_phase270),
        .i_last  (i_last_in_frame),
        .o_valid (w_ang_vld),
        .o_item  (w_ang_item)
    );

    fspd_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_period (r_fringe_period),
        .i_valid  (w_ang_vld),
        .i_item   (w_ang_item),
        .o_valid  (w_res_vld),
        .o_item   (w_res_item)
    );

    // two-entry output buffer, head in r_buf0
    assign w_push = w_res_vld && w_en;
    assign w_pop  = o_out_valid && i_out_ready;

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (!w_push && w_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (r_count == 2'd2) begin
                r_buf0 <= r_buf1;
            end else begin
                r_buf0 <= w_res_item;
            end
            if (w_push && (r_count == 2'd2)) begin
                r_buf1 <= w_res_item;
            end
        end else if (w_push) begin
            if (r_count == 2'd0) begin
                r_buf0 <= w_res_item;
            end else begin
                r_buf1 <= w_res_item;
            end
        end
    end

    assign o_out_valid    = (r_count != 2'd0);
    assign o_pixel_offset = r_buf0.offset;
    assign o_phase_angle  = r_buf0.phase;
    assign o_frame_end    = r_buf0.last;

    `ASSERT_NEVER(a_buf_overflow, i_clk, i_rst_n, r_count == 2'd3, "output buffer count out of range")
    `ASSERT_AT(a_no_push_full, i_clk, i_rst_n, (r_count == 2'd2) |=> (r_count != 2'd3), "transfer into full output buffer")
    `ASSERT_AT(a_phase_range, i_clk, i_rst_n, o_out_valid |-> (o_phase_angle < C_PHASE_WRAP), "phase angle not wrapped")

endmodule
